### rtl/pss_pkg.sv
// ----------------------------------------------------------------------------
// pss_pkg
// Shared types, phase codes, register map and burst constants for the
// pressure stepper sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package pss_pkg;

    localparam int PRESSURE_BITS_DEF = 20;
    localparam int BAND_BITS         = 20;
    localparam int TIME_BITS         = 32;
    localparam int SETTLE_BITS       = 16;
    localparam int ADDR_BITS         = 5;
    localparam int DATA_BITS         = 32;

    // run phases
    localparam logic [2:0] PH_IDLE     = 3'd0;
    localparam logic [2:0] PH_APPROACH = 3'd1;
    localparam logic [2:0] PH_FINE     = 3'd2;
    localparam logic [2:0] PH_SETTLE   = 3'd3;
    localparam logic [2:0] PH_DWELL    = 3'd4;
    localparam logic [2:0] PH_REVERSE  = 3'd5;

    // request kinds
    localparam logic REQ_SAMPLE = 1'b0;
    localparam logic REQ_START  = 1'b1;

    // register indexes (byte address 4*index)
    localparam logic [2:0] REG_APPROACH = 3'd0;
    localparam logic [2:0] REG_REVERSE  = 3'd1;
    localparam logic [2:0] REG_SETTLE   = 3'd2;
    localparam logic [2:0] REG_DEADBAND = 3'd3;
    localparam logic [2:0] REG_FAR      = 3'd4;
    localparam logic [2:0] REG_NEAR     = 3'd5;
    localparam logic [2:0] REG_FINE     = 3'd6;
    localparam logic [2:0] REG_SLOPE    = 3'd7;

    // register reset values
    localparam logic [TIME_BITS-1:0]   APPROACH_RST = 32'd5000;
    localparam logic [TIME_BITS-1:0]   REVERSE_RST  = 32'd6000;
    localparam logic [SETTLE_BITS-1:0] SETTLE_RST   = 16'd300;
    localparam logic [BAND_BITS-1:0]   DEADBAND_RST = 20'd300;
    localparam logic [BAND_BITS-1:0]   FAR_RST      = 20'd2000;
    localparam logic [BAND_BITS-1:0]   NEAR_RST     = 20'd500;
    localparam logic [BAND_BITS-1:0]   FINE_RST     = 20'd50;
    localparam logic [BAND_BITS-1:0]   SLOPE_RST    = 20'd100;

    // burst shapes
    localparam logic [6:0]  STEPS_NONE   = 7'd0;
    localparam logic [6:0]  STEPS_ONE    = 7'd1;
    localparam logic [6:0]  STEPS_NEAR   = 7'd8;
    localparam logic [6:0]  STEPS_FAST   = 7'd64;
    localparam logic [11:0] PERIOD_NONE  = 12'd0;
    localparam logic [11:0] PERIOD_FAST  = 12'd500;
    localparam logic [11:0] PERIOD_NEAR  = 12'd2000;
    localparam logic [11:0] PERIOD_FINE  = 12'd3000;
    localparam logic [11:0] PERIOD_FAR   = 12'd4000;

    typedef struct packed {
        logic [TIME_BITS-1:0]   approach_ms;
        logic [TIME_BITS-1:0]   reverse_ms;
        logic [SETTLE_BITS-1:0] settle_ms;
        logic [BAND_BITS-1:0]   deadband_mpsi;
        logic [BAND_BITS-1:0]   far_band_mpsi;
        logic [BAND_BITS-1:0]   near_band_mpsi;
        logic [BAND_BITS-1:0]   fine_band_mpsi;
        logic [BAND_BITS-1:0]   slope_hold_mpsi;
    } cfg_t;

    typedef struct packed {
        logic [6:0]  step_count;
        logic [11:0] step_period_us;
        logic        step_reverse;
        logic [2:0]  phase;
        logic        run_done;
    } burst_t;

endpackage

`default_nettype wire

### rtl/pressure_stepper_sequencer.sv
// An accepted request waits in the input register; its burst result then goes
// to the result register. Throughput: one request per cycle while burst_stall
// is low; the decision logic between the two registers is combinational.
// The output register holds a result under stall while the next request waits
// in the input register. Reset (rst_n low, asynchronous) returns to idle, clears
// the run state and loads the default register values.
// ----------------------------------------------------------------------------
// pressure_stepper_sequencer
// Run sequencer for a stepper-driven pressure source: approach, fine control,
// settle, dwell and reverse, one step burst command per request.
// ----------------------------------------------------------------------------
`default_nettype none

module pressure_stepper_sequencer
#(
    parameter int PRESSURE_BITS = pss_pkg::PRESSURE_BITS_DEF
)
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    // configuration port
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [pss_pkg::ADDR_BITS-1:0]  paddr,
    input  wire logic [pss_pkg::DATA_BITS-1:0]  pwdata,
    output logic      [pss_pkg::DATA_BITS-1:0]  prdata,
    output logic                                pready,
    // request channel
    input  wire logic                           item_valid,
    output logic                                item_stall,
    input  wire logic                           req_type,
    input  wire logic [pss_pkg::TIME_BITS-1:0]  now_ms,
    input  wire logic [PRESSURE_BITS-1:0]       pressure_mpsi,
    input  wire logic [PRESSURE_BITS-1:0]       target_mpsi,
    input  wire logic [pss_pkg::TIME_BITS-1:0]  dwell_len_ms,
    // burst channel
    output logic                                burst_valid,
    input  wire logic                           burst_stall,
    output logic [6:0]                          step_count,
    output logic [11:0]                         step_period_us,
    output logic                                step_reverse,
    output logic [2:0]                          phase,
    output logic                                run_done
);
    import pss_pkg::*;

    cfg_t cfg;

    // input register
    logic                       in_valid_reg;
    logic                       in_req_reg;
    logic [TIME_BITS-1:0]       in_now_reg;
    logic [PRESSURE_BITS-1:0]   in_pres_reg;
    logic [PRESSURE_BITS-1:0]   in_tgt_reg;
    logic [TIME_BITS-1:0]       in_dwell_reg;

    // run state
    logic [2:0]                 phase_reg;
    logic [2:0]                 phase_next;
    logic [TIME_BITS-1:0]       phase_end_reg;
    logic [TIME_BITS-1:0]       phase_end_next;
    logic [TIME_BITS-1:0]       dwell_hold_reg;
    logic [TIME_BITS-1:0]       dwell_hold_next;
    logic [PRESSURE_BITS-1:0]   target_hold_reg;
    logic [PRESSURE_BITS-1:0]   target_hold_next;
    logic signed [PRESSURE_BITS:0] prev_error_reg;
    logic signed [PRESSURE_BITS:0] prev_error_next;

    // result register
    logic                       out_valid_reg;
    burst_t                     out_reg;
    burst_t                     res;

    logic                       advance;
    logic                       accept;

    pss_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    pss_step #(.PRESSURE_BITS(PRESSURE_BITS)) u_step
    (
        .cur_phase     (phase_reg),
        .cur_end       (phase_end_reg),
        .cur_dwell     (dwell_hold_reg),
        .cur_target    (target_hold_reg),
        .cur_prev_err  (prev_error_reg),
        .req_type      (in_req_reg),
        .now_ms        (in_now_reg),
        .pressure_mpsi (in_pres_reg),
        .target_mpsi   (in_tgt_reg),
        .dwell_len_ms  (in_dwell_reg),
        .cfg           (cfg),
        .nxt_phase     (phase_next),
        .nxt_end       (phase_end_next),
        .nxt_dwell     (dwell_hold_next),
        .nxt_target    (target_hold_next),
        .nxt_prev_err  (prev_error_next),
        .res           (res)
    );

    // a held request moves on whenever the result register is free or draining
    assign advance    = in_valid_reg && (!out_valid_reg || !burst_stall);
    assign item_stall = in_valid_reg && !advance;
    assign accept     = item_valid && !item_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            phase_reg       <= PH_IDLE;
            phase_end_reg   <= '0;
            dwell_hold_reg  <= '0;
            target_hold_reg <= '0;
            prev_error_reg  <= '0;
        end
        else
        begin
            if (accept)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                out_valid_reg   <= 1'b1;
                phase_reg       <= phase_next;
                phase_end_reg   <= phase_end_next;
                dwell_hold_reg  <= dwell_hold_next;
                target_hold_reg <= target_hold_next;
                prev_error_reg  <= prev_error_next;
            end
            else if (!burst_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_req_reg   <= req_type;
            in_now_reg   <= now_ms;
            in_pres_reg  <= pressure_mpsi;
            in_tgt_reg   <= target_mpsi;
            in_dwell_reg <= dwell_len_ms;
        end
        if (advance)
        begin
            out_reg <= res;
        end
    end

    assign burst_valid    = out_valid_reg;
    assign step_count     = out_reg.step_count;
    assign step_period_us = out_reg.step_period_us;
    assign step_reverse   = out_reg.step_reverse;
    assign phase          = out_reg.phase;
    assign run_done       = out_reg.run_done;

endmodule

`default_nettype wire

### rtl/pss_regs.sv
// ----------------------------------------------------------------------------
// pss_regs
// Configuration register file behind a simple APB-style slave port.
// ----------------------------------------------------------------------------
`default_nettype none

module pss_regs
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [pss_pkg::ADDR_BITS-1:0]  paddr,
    input  wire logic [pss_pkg::DATA_BITS-1:0]  pwdata,
    output logic      [pss_pkg::DATA_BITS-1:0]  prdata,
    output logic                                pready,
    output pss_pkg::cfg_t                       cfg
);
    import pss_pkg::*;

    cfg_t       cfg_reg;
    logic       wr_en;
    logic [2:0] idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign idx    = paddr[4:2];
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.approach_ms     <= APPROACH_RST;
            cfg_reg.reverse_ms      <= REVERSE_RST;
            cfg_reg.settle_ms       <= SETTLE_RST;
            cfg_reg.deadband_mpsi   <= DEADBAND_RST;
            cfg_reg.far_band_mpsi   <= FAR_RST;
            cfg_reg.near_band_mpsi  <= NEAR_RST;
            cfg_reg.fine_band_mpsi  <= FINE_RST;
            cfg_reg.slope_hold_mpsi <= SLOPE_RST;
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_APPROACH: cfg_reg.approach_ms     <= pwdata;
                REG_REVERSE:  cfg_reg.reverse_ms      <= pwdata;
                REG_SETTLE:   cfg_reg.settle_ms       <= pwdata[SETTLE_BITS-1:0];
                REG_DEADBAND: cfg_reg.deadband_mpsi   <= pwdata[BAND_BITS-1:0];
                REG_FAR:      cfg_reg.far_band_mpsi   <= pwdata[BAND_BITS-1:0];
                REG_NEAR:     cfg_reg.near_band_mpsi  <= pwdata[BAND_BITS-1:0];
                REG_FINE:     cfg_reg.fine_band_mpsi  <= pwdata[BAND_BITS-1:0];
                REG_SLOPE:    cfg_reg.slope_hold_mpsi <= pwdata[BAND_BITS-1:0];
                default:      ;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_APPROACH: prdata = cfg_reg.approach_ms;
            REG_REVERSE:  prdata = cfg_reg.reverse_ms;
            REG_SETTLE:   prdata = {{(DATA_BITS-SETTLE_BITS){1'b0}}, cfg_reg.settle_ms};
            REG_DEADBAND: prdata = {{(DATA_BITS-BAND_BITS){1'b0}}, cfg_reg.deadband_mpsi};
            REG_FAR:      prdata = {{(DATA_BITS-BAND_BITS){1'b0}}, cfg_reg.far_band_mpsi};
            REG_NEAR:     prdata = {{(DATA_BITS-BAND_BITS){1'b0}}, cfg_reg.near_band_mpsi};
            REG_FINE:     prdata = {{(DATA_BITS-BAND_BITS){1'b0}}, cfg_reg.fine_band_mpsi};
            REG_SLOPE:    prdata = {{(DATA_BITS-BAND_BITS){1'b0}}, cfg_reg.slope_hold_mpsi};
            default:      prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

### rtl/pss_step.sv
// ----------------------------------------------------------------------------
// pss_step
// Per-request decision logic: phase transitions, deadlines and the step
// burst for one request, given the current run state.
// ----------------------------------------------------------------------------
`default_nettype none

module pss_step
#(
    parameter int PRESSURE_BITS = pss_pkg::PRESSURE_BITS_DEF
)
(
    input  wire logic [2:0]                      cur_phase,
    input  wire logic [pss_pkg::TIME_BITS-1:0]   cur_end,
    input  wire logic [pss_pkg::TIME_BITS-1:0]   cur_dwell,
    input  wire logic [PRESSURE_BITS-1:0]        cur_target,
    input  wire logic signed [PRESSURE_BITS:0]   cur_prev_err,
    input  wire logic                            req_type,
    input  wire logic [pss_pkg::TIME_BITS-1:0]   now_ms,
    input  wire logic [PRESSURE_BITS-1:0]        pressure_mpsi,
    input  wire logic [PRESSURE_BITS-1:0]        target_mpsi,
    input  wire logic [pss_pkg::TIME_BITS-1:0]   dwell_len_ms,
    input  wire pss_pkg::cfg_t                   cfg,
    output logic [2:0]                           nxt_phase,
    output logic [pss_pkg::TIME_BITS-1:0]        nxt_end,
    output logic [pss_pkg::TIME_BITS-1:0]        nxt_dwell,
    output logic [PRESSURE_BITS-1:0]             nxt_target,
    output logic signed [PRESSURE_BITS:0]        nxt_prev_err,
    output pss_pkg::burst_t                      res
);
    import pss_pkg::*;

    localparam int MAXW = (PRESSURE_BITS > BAND_BITS) ? PRESSURE_BITS : BAND_BITS;
    localparam int EW   = MAXW + 3;

    logic                 expired;
    logic signed [EW-1:0] err;
    logic signed [EW-1:0] prev_ext;
    logic signed [EW-1:0] slope;
    logic signed [EW-1:0] db;
    logic signed [EW-1:0] far_b;
    logic signed [EW-1:0] near_b;
    logic signed [EW-1:0] fine_b;
    logic signed [EW-1:0] hold_b;
    logic                 in_band;

    assign expired  = now_ms >= cur_end;
    assign err      = $signed({{(EW-PRESSURE_BITS){1'b0}}, cur_target})
                    - $signed({{(EW-PRESSURE_BITS){1'b0}}, pressure_mpsi});
    assign prev_ext = {{(EW-PRESSURE_BITS-1){cur_prev_err[PRESSURE_BITS]}}, cur_prev_err};
    assign slope    = err - prev_ext;
    assign db       = $signed({{(EW-BAND_BITS){1'b0}}, cfg.deadband_mpsi});
    assign far_b    = $signed({{(EW-BAND_BITS){1'b0}}, cfg.far_band_mpsi});
    assign near_b   = $signed({{(EW-BAND_BITS){1'b0}}, cfg.near_band_mpsi});
    assign fine_b   = $signed({{(EW-BAND_BITS){1'b0}}, cfg.fine_band_mpsi});
    assign hold_b   = $signed({{(EW-BAND_BITS){1'b0}}, cfg.slope_hold_mpsi});
    assign in_band  = (err <= db) && (err >= -db);

    always_comb
    begin
        nxt_phase    = cur_phase;
        nxt_end      = cur_end;
        nxt_dwell    = cur_dwell;
        nxt_target   = cur_target;
        nxt_prev_err = cur_prev_err;
        res.step_count     = STEPS_NONE;
        res.step_period_us = PERIOD_NONE;
        res.step_reverse   = 1'b0;
        res.run_done       = 1'b0;

        if (req_type == REQ_START)
        begin
            // start is only honored from idle or from a stray phase code
            if (cur_phase == PH_IDLE || cur_phase > PH_REVERSE)
            begin
                nxt_target = target_mpsi;
                nxt_dwell  = dwell_len_ms;
                nxt_phase  = PH_APPROACH;
                nxt_end    = now_ms + cfg.approach_ms;
            end
        end
        else
        begin
            unique case (cur_phase)
                PH_APPROACH:
                begin
                    if (expired)
                    begin
                        nxt_phase = PH_FINE;
                    end
                    else if (pressure_mpsi >= cur_target)
                    begin
                        nxt_phase = PH_DWELL;
                        nxt_end   = now_ms + cur_dwell;
                    end
                    else
                    begin
                        res.step_count     = STEPS_FAST;
                        res.step_period_us = PERIOD_FAST;
                    end
                end
                PH_FINE:
                begin
                    priority if (in_band)
                    begin
                        nxt_phase = PH_SETTLE;
                        nxt_end   = now_ms + {{(TIME_BITS-SETTLE_BITS){1'b0}}, cfg.settle_ms};
                    end
                    else if (err > far_b)
                    begin
                        res.step_count     = STEPS_ONE;
                        res.step_period_us = PERIOD_FAR;
                    end
                    else if (err > near_b)
                    begin
                        res.step_count     = STEPS_NEAR;
                        res.step_period_us = PERIOD_NEAR;
                    end
                    else if (err > fine_b)
                    begin
                        res.step_count     = STEPS_ONE;
                        res.step_period_us = PERIOD_FINE;
                    end
                    else if (err < -fine_b)
                    begin
                        res.step_count     = STEPS_ONE;
                        res.step_period_us = PERIOD_FINE;
                        res.step_reverse   = 1'b1;
                    end
                    else
                    begin
                        res.step_count = STEPS_NONE;
                    end
                end
                PH_SETTLE:
                begin
                    if (expired)
                    begin
                        if (in_band)
                        begin
                            nxt_phase = PH_DWELL;
                            nxt_end   = now_ms + cur_dwell;
                        end
                        else
                        begin
                            nxt_phase = PH_FINE;
                        end
                    end
                end
                PH_DWELL:
                begin
                    nxt_prev_err = err[PRESSURE_BITS:0];
                    priority if (expired)
                    begin
                        nxt_prev_err = '0;
                        nxt_phase    = PH_REVERSE;
                        nxt_end      = now_ms + cfg.reverse_ms;
                    end
                    else if (in_band && (slope > -hold_b))
                    begin
                        // on target and not falling fast: hold
                        res.step_count = STEPS_NONE;
                    end
                    else if ((err > db) || (slope < -db))
                    begin
                        res.step_count     = STEPS_ONE;
                        res.step_period_us = PERIOD_FINE;
                    end
                    else if ((err < -db) || (slope > db))
                    begin
                        res.step_count     = STEPS_ONE;
                        res.step_period_us = PERIOD_FINE;
                        res.step_reverse   = 1'b1;
                    end
                    else
                    begin
                        res.step_count = STEPS_NONE;
                    end
                end
                PH_REVERSE:
                begin
                    if (expired)
                    begin
                        nxt_phase    = PH_IDLE;
                        res.run_done = 1'b1;
                    end
                    else
                    begin
                        res.step_count     = STEPS_FAST;
                        res.step_period_us = PERIOD_FAST;
                        res.step_reverse   = 1'b1;
                    end
                end
                default:
                begin
                    // idle, and any stray code acts as idle
                    nxt_phase = PH_IDLE;
                end
            endcase
        end

        res.phase = nxt_phase;
    end

endmodule

`default_nettype wire

### rtl/pss_checker.sv
// ----------------------------------------------------------------------------
// pss_checker
// Port-level checks on the burst results of the sequencer, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module pss_checker
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        burst_valid,
    input wire logic        burst_stall,
    input wire logic [6:0]  step_count,
    input wire logic [11:0] step_period_us,
    input wire logic        step_reverse,
    input wire logic [2:0]  phase,
    input wire logic        run_done
);
    import pss_pkg::*;

    // a finished run always lands in idle
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        burst_valid && run_done |-> phase == PH_IDLE)
        else $error("run_done without idle phase");

    // no steps means a clean burst word
    a_no_step_clean: assert property (@(posedge clk) disable iff (!rst_n)
        burst_valid && step_count == STEPS_NONE |->
            step_period_us == PERIOD_NONE && !step_reverse)
        else $error("empty burst carries period or direction");

    // fast bursts only in approach (forward) or reverse (backward)
    a_fast_phase: assert property (@(posedge clk) disable iff (!rst_n)
        burst_valid && step_count == STEPS_FAST |->
            step_period_us == PERIOD_FAST &&
            ((phase == PH_APPROACH && !step_reverse) ||
             (phase == PH_REVERSE && step_reverse)))
        else $error("fast burst outside approach or reverse");

    // a stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        burst_valid && burst_stall |=>
            burst_valid && $stable(step_count) && $stable(phase) && $stable(run_done))
        else $error("stalled burst changed");

endmodule

bind pressure_stepper_sequencer pss_checker u_pss_checker
(
    .clk            (clk),
    .rst_n          (rst_n),
    .burst_valid    (burst_valid),
    .burst_stall    (burst_stall),
    .step_count     (step_count),
    .step_period_us (step_period_us),
    .step_reverse   (step_reverse),
    .phase          (phase),
    .run_done       (run_done)
);

`default_nettype wire

### tb/tb_pressure_stepper_sequencer.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_pressure_stepper_sequencer
// Self-checking bench for the pressure stepper sequencer. A short table of
// directed requests walks one full run (approach, fine, settle, dwell,
// reverse), an early target hit and a wrapped deadline. Random runs follow
// under several register settings. Every accepted request is put through
// a local model of the run sequencer, and each burst leaving the block is
// compared field by field with the oldest predicted burst. Random gaps on
// both channels, plus one long output hold-off that backs up the input.
// ----------------------------------------------------------------------------
module tb_pressure_stepper_sequencer;

    import pss_pkg::*;

    localparam int PW = PRESSURE_BITS_DEF;
    localparam logic [PW-1:0] PMAX = '1;
    localparam int unsigned CYCLE_LIMIT = 600000;
    localparam int unsigned CHOKE_CYCLES = 300;
    localparam int DRAIN_CYCLES = 8;

    typedef struct packed {
        logic          req_type;
        logic [31:0]   now_ms;
        logic [PW-1:0] pressure;
        logic [PW-1:0] target;
        logic [31:0]   dwell;
    } run_req_t;

    typedef struct packed {
        logic     typed;
        run_req_t req;
        burst_t   result;
    } plan_row_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [ADDR_BITS-1:0] paddr = '0;
    logic [DATA_BITS-1:0] pwdata = '0;
    logic [DATA_BITS-1:0] prdata;
    logic                 pready;
    logic                 item_valid = 1'b0;
    logic                 item_stall;
    logic                 req_type = REQ_SAMPLE;
    logic [TIME_BITS-1:0] now_ms = '0;
    logic [PW-1:0]        pressure_mpsi = '0;
    logic [PW-1:0]        target_mpsi = '0;
    logic [TIME_BITS-1:0] dwell_len_ms = '0;
    logic                 burst_valid;
    logic                 burst_stall = 1'b0;
    logic [6:0]           step_count;
    logic [11:0]          step_period_us;
    logic                 step_reverse;
    logic [2:0]           phase;
    logic                 run_done;

    pressure_stepper_sequencer DUT (.*);

    always #6 clk = ~clk;

    // model state
    cfg_t cfg = '{APPROACH_RST, REVERSE_RST, SETTLE_RST, DEADBAND_RST,
                  FAR_RST, NEAR_RST, FINE_RST, SLOPE_RST};
    logic [2:0]    run_phase = PH_IDLE;
    logic [31:0]   run_deadline = '0;
    logic [31:0]   held_dwell = '0;
    logic [PW-1:0] held_target = '0;
    longint        last_dwell_err = 0;

    burst_t      burst_q[$];
    plan_row_t   plan_q[$];
    int          n_errors = 0;
    int unsigned cycles = 0;
    bit          no_gaps = 1'b0;
    bit          choke_pending = 1'b0;
    int unsigned choke_left = 0;
    int unsigned hold_left = 0;
    int unsigned free_left = 0;
    int unsigned tick_span = 2500;
    logic [31:0] clock_ms = '0;

    function automatic longint mag(input longint v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic burst_t make_burst(input logic [6:0] cnt, input logic [11:0] per,
                                          input logic rev, input logic [2:0] ph,
                                          input logic done);
        burst_t b;
        b.step_count = cnt;
        b.step_period_us = per;
        b.step_reverse = rev;
        b.phase = ph;
        b.run_done = done;
        return b;
    endfunction

    // one request through the run sequencer, returns the burst it causes
    function automatic burst_t advance_sequencer(input run_req_t r);
        burst_t b;
        logic   expired;
        logic   done;
        longint err;
        longint db;
        longint slope;
        b = make_burst(STEPS_NONE, PERIOD_NONE, 1'b0, PH_IDLE, 1'b0);
        done = 1'b0;
        expired = (r.now_ms >= run_deadline);
        err = longint'(held_target) - longint'(r.pressure);
        db = longint'(cfg.deadband_mpsi);
        if (run_phase > PH_REVERSE)
            run_phase = PH_IDLE;
        if (r.req_type == REQ_START)
        begin
            if (run_phase == PH_IDLE)
            begin
                held_target = r.target;
                held_dwell = r.dwell;
                run_phase = PH_APPROACH;
                run_deadline = r.now_ms + cfg.approach_ms;
            end
        end
        else
        begin
            case (run_phase)
                PH_APPROACH:
                begin
                    if (expired)
                        run_phase = PH_FINE;
                    else if (r.pressure >= held_target)
                    begin
                        run_phase = PH_DWELL;
                        run_deadline = r.now_ms + held_dwell;
                    end
                    else
                        b = make_burst(STEPS_FAST, PERIOD_FAST, 1'b0, PH_IDLE, 1'b0);
                end
                PH_FINE:
                begin
                    if (mag(err) <= db)
                    begin
                        run_phase = PH_SETTLE;
                        run_deadline = r.now_ms + cfg.settle_ms;
                    end
                    else if (err > longint'(cfg.far_band_mpsi))
                        b = make_burst(STEPS_ONE, PERIOD_FAR, 1'b0, PH_IDLE, 1'b0);
                    else if (err > longint'(cfg.near_band_mpsi))
                        b = make_burst(STEPS_NEAR, PERIOD_NEAR, 1'b0, PH_IDLE, 1'b0);
                    else if (err > longint'(cfg.fine_band_mpsi))
                        b = make_burst(STEPS_ONE, PERIOD_FINE, 1'b0, PH_IDLE, 1'b0);
                    else if (err < -longint'(cfg.fine_band_mpsi))
                        b = make_burst(STEPS_ONE, PERIOD_FINE, 1'b1, PH_IDLE, 1'b0);
                end
                PH_SETTLE:
                begin
                    if (expired)
                    begin
                        if (mag(err) <= db)
                        begin
                            run_phase = PH_DWELL;
                            run_deadline = r.now_ms + held_dwell;
                        end
                        else
                            run_phase = PH_FINE;
                    end
                end
                PH_DWELL:
                begin
                    slope = err - last_dwell_err;
                    last_dwell_err = err;
                    if (expired)
                    begin
                        last_dwell_err = 0;
                        run_phase = PH_REVERSE;
                        run_deadline = r.now_ms + cfg.reverse_ms;
                    end
                    else if (mag(err) <= db && slope > -longint'(cfg.slope_hold_mpsi))
                    begin
                        // on target and not falling fast
                    end
                    else if (err > db || slope < -db)
                        b = make_burst(STEPS_ONE, PERIOD_FINE, 1'b0, PH_IDLE, 1'b0);
                    else if (err < -db || slope > db)
                        b = make_burst(STEPS_ONE, PERIOD_FINE, 1'b1, PH_IDLE, 1'b0);
                end
                PH_REVERSE:
                begin
                    if (expired)
                    begin
                        run_phase = PH_IDLE;
                        done = 1'b1;
                    end
                    else
                        b = make_burst(STEPS_FAST, PERIOD_FAST, 1'b1, PH_IDLE, 1'b0);
                end
                default:
                begin
                end
            endcase
        end
        b.phase = run_phase;
        b.run_done = done;
        return b;
    endfunction

    function automatic int unsigned idle_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 50)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 15);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [31:0] next_now();
        if ($urandom_range(0, 99) < 3)
            clock_ms = $urandom;
        else
            clock_ms = clock_ms + $urandom_range(0, tick_span);
        return clock_ms;
    endfunction

    // pressure around the held target, some picks right at a band edge
    function automatic logic [PW-1:0] pick_pressure();
        int unsigned r;
        int unsigned lim;
        longint      off;
        longint      p;
        r = $urandom_range(0, 99);
        if (r < 6)
            return PW'($urandom);
        if (r < 16)
        begin
            case ($urandom_range(0, 3))
                0: lim = cfg.deadband_mpsi;
                1: lim = cfg.fine_band_mpsi;
                2: lim = cfg.near_band_mpsi;
                default: lim = cfg.far_band_mpsi;
            endcase
            off = longint'(lim) + $urandom_range(0, 1);
        end
        else if (r < 50)
            off = $urandom_range(0, cfg.deadband_mpsi + 1);
        else if (r < 70)
            off = $urandom_range(0, cfg.near_band_mpsi + cfg.fine_band_mpsi + 1);
        else if (r < 88)
            off = $urandom_range(0, cfg.far_band_mpsi + cfg.far_band_mpsi / 2 + 2);
        else
            off = $urandom_range(0, 4 * cfg.far_band_mpsi + 100);
        // approach mostly stays under target so the timed exit is reached
        if ($urandom_range(0, 99) < ((run_phase == PH_APPROACH) ? 85 : 50))
            off = -off;
        p = longint'(held_target) + off;
        if (p < 0)
            p = 0;
        if (p > longint'(PMAX))
            p = longint'(PMAX);
        return p[PW-1:0];
    endfunction

    function automatic cfg_t random_settings();
        cfg_t c;
        c.approach_ms = $urandom_range(0, 4000);
        c.reverse_ms = $urandom_range(0, 4000);
        c.settle_ms = $urandom_range(0, 600);
        c.deadband_mpsi = $urandom_range(0, 1500);
        c.far_band_mpsi = $urandom_range(0, 20000);
        c.near_band_mpsi = $urandom_range(0, 6000);
        c.fine_band_mpsi = $urandom_range(0, 600);
        c.slope_hold_mpsi = $urandom_range(0, 1500);
        return c;
    endfunction

    function automatic void add_row(input bit typed, input logic kind, input logic [31:0] t,
                                    input logic [PW-1:0] pres, input logic [PW-1:0] tgt,
                                    input logic [31:0] dwell, input burst_t res);
        plan_row_t row;
        row.typed = typed;
        row.req = '{kind, t, pres, tgt, dwell};
        row.result = res;
        plan_q.push_back(row);
    endfunction

    task automatic send_req(input run_req_t r, input bit typed, input burst_t typed_result);
        int unsigned gap;
        burst_t      predicted;
        gap = idle_gap();
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        req_type <= r.req_type;
        now_ms <= r.now_ms;
        pressure_mpsi <= r.pressure;
        target_mpsi <= r.target;
        dwell_len_ms <= r.dwell;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        predicted = advance_sequencer(r);
        burst_q.push_back(typed ? typed_result : predicted);
    endtask

    task automatic drive_runs(input int n);
        run_req_t    r;
        int unsigned pick;
        for (int i = 0; i < n; i++)
        begin
            pick = $urandom_range(0, 99);
            r.now_ms = next_now();
            r.pressure = pick_pressure();
            r.target = PW'($urandom);
            r.dwell = $urandom;
            r.req_type = REQ_SAMPLE;
            // a few starts land mid-run and must be ignored
            if ((run_phase == PH_IDLE && pick < 85) || pick < 3)
            begin
                r.req_type = REQ_START;
                case ($urandom_range(0, 19))
                    0: r.target = '0;
                    1: r.target = PMAX;
                    default: ;
                endcase
                if ($urandom_range(0, 19) != 0)
                    r.dwell = $urandom_range(0, 8 * tick_span);
            end
            send_req(r, 1'b0, '0);
        end
    endtask

    task automatic drain_bursts();
        item_valid <= 1'b0;
        while (burst_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_APPROACH: cfg.approach_ms = val;
            REG_REVERSE:  cfg.reverse_ms = val;
            REG_SETTLE:   cfg.settle_ms = val[SETTLE_BITS-1:0];
            REG_DEADBAND: cfg.deadband_mpsi = val[BAND_BITS-1:0];
            REG_FAR:      cfg.far_band_mpsi = val[BAND_BITS-1:0];
            REG_NEAR:     cfg.near_band_mpsi = val[BAND_BITS-1:0];
            REG_FINE:     cfg.fine_band_mpsi = val[BAND_BITS-1:0];
            REG_SLOPE:    cfg.slope_hold_mpsi = val[BAND_BITS-1:0];
            default: ;
        endcase
    endtask

    task automatic load_settings(input cfg_t c);
        write_reg(REG_APPROACH, c.approach_ms);
        write_reg(REG_REVERSE, c.reverse_ms);
        write_reg(REG_SETTLE, 32'(c.settle_ms));
        write_reg(REG_DEADBAND, 32'(c.deadband_mpsi));
        write_reg(REG_FAR, 32'(c.far_band_mpsi));
        write_reg(REG_NEAR, 32'(c.near_band_mpsi));
        write_reg(REG_FINE, 32'(c.fine_band_mpsi));
        write_reg(REG_SLOPE, 32'(c.slope_hold_mpsi));
    endtask

    // output side: random stalls, plus one long hold-off on request
    always @(posedge clk)
    begin
        if (choke_pending)
        begin
            choke_pending = 1'b0;
            choke_left = CHOKE_CYCLES;
        end
        if (choke_left > 0)
        begin
            choke_left--;
            burst_stall <= 1'b1;
        end
        else if (no_gaps)
            burst_stall <= 1'b0;
        else if (hold_left > 0)
        begin
            hold_left--;
            burst_stall <= 1'b1;
        end
        else if (free_left > 0)
        begin
            free_left--;
            burst_stall <= 1'b0;
        end
        else
        begin
            hold_left = idle_gap();
            free_left = $urandom_range(0, 10);
            burst_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        burst_t want;
        if (rst_n && burst_valid && !burst_stall)
        begin
            if (burst_q.size() == 0)
            begin
                $error("burst with no request pending");
                n_errors++;
            end
            else
            begin
                want = burst_q.pop_front();
                if (step_count !== want.step_count)
                begin
                    $error("step_count expected %0d got %0d", want.step_count, step_count);
                    n_errors++;
                end
                if (step_period_us !== want.step_period_us)
                begin
                    $error("step_period_us expected %0d got %0d",
                           want.step_period_us, step_period_us);
                    n_errors++;
                end
                if (step_reverse !== want.step_reverse)
                begin
                    $error("step_reverse expected %0d got %0d", want.step_reverse, step_reverse);
                    n_errors++;
                end
                if (phase !== want.phase)
                begin
                    $error("phase expected %0d got %0d", want.phase, phase);
                    n_errors++;
                end
                if (run_done !== want.run_done)
                begin
                    $error("run_done expected %0d got %0d", want.run_done, run_done);
                    n_errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb_pressure_stepper_sequencer: errors");
            $finish;
        end
    end

    initial
    begin
        plan_row_t row;

        // idle sample, start, a start that is ignored, fast approach, timed exit
        add_row(1, REQ_SAMPLE, 32'd0, PMAX, '0, 32'd0,
                make_burst(STEPS_NONE, PERIOD_NONE, 1'b0, PH_IDLE, 1'b0));
        add_row(1, REQ_START, 32'd1000, '0, 20'd10000, 32'd2000,
                make_burst(STEPS_NONE, PERIOD_NONE, 1'b0, PH_APPROACH, 1'b0));
        add_row(1, REQ_START, 32'd1100, '0, PMAX, 32'hFFFF_FFFF,
                make_burst(STEPS_NONE, PERIOD_NONE, 1'b0, PH_APPROACH, 1'b0));
        add_row(1, REQ_SAMPLE, 32'd1200, '0, '0, 32'd0,
                make_burst(STEPS_FAST, PERIOD_FAST, 1'b0, PH_APPROACH, 1'b0));
        add_row(1, REQ_SAMPLE, 32'd6000, '0, '0, 32'd0,
                make_burst(STEPS_NONE, PERIOD_NONE, 1'b0, PH_FINE, 1'b0));
        // fine bands: far, near, fine forward, fine backward, then into settle
        add_row(0, REQ_SAMPLE, 32'd6100, '0, '0, 32'd0, '0);
        add_row(0, REQ_SAMPLE, 32'd6150, 20'd8500, '0, 32'd0, '0);
        add_row(0, REQ_SAMPLE, 32'd6200, 20'd9600, '0, 32'd0, '0);
        add_row(0, REQ_SAMPLE, 32'd6250, 20'd10400, '0, 32'd0, '0);
        add_row(0, REQ_SAMPLE, 32'd6500, 20'd10000, '0, 32'd0, '0);
        // settle wait, failed recheck, settle again, good recheck into dwell
        add_row(0, REQ_SAMPLE, 32'd6600, 20'd12000, '0, 32'd0, '0);
        add_row(0, REQ_SAMPLE, 32'd6800, 20'd11000, '0, 32'd0, '0);
        add_row(0, REQ_SAMPLE, 32'd6900, 20'd10100, '0, 32'd0, '0);
        add_row(0, REQ_SAMPLE, 32'd7200, 20'd10050, '0, 32'd0, '0);
        // dwell nudges driven by error and by slope
        add_row(0, REQ_SAMPLE, 32'd7400, 20'd10250, '0, 32'd0, '0);
        add_row(0, REQ_SAMPLE, 32'd7500, 20'd9500, '0, 32'd0, '0);
        add_row(0, REQ_SAMPLE, 32'd7600, 20'd10600, '0, 32'd0, '0);
        add_row(0, REQ_SAMPLE, 32'd7700, 20'd10400, '0, 32'd0, '0);
        add_row(0, REQ_SAMPLE, 32'd9200, '0, '0, 32'd0, '0);
        add_row(1, REQ_SAMPLE, 32'd15200, '0, '0, 32'd0,
                make_burst(STEPS_NONE, PERIOD_NONE, 1'b0, PH_IDLE, 1'b1));
        // early target hit goes straight to dwell
        add_row(1, REQ_START, 32'd20000, PMAX, '0, 32'd0,
                make_burst(STEPS_NONE, PERIOD_NONE, 1'b0, PH_APPROACH, 1'b0));
        add_row(0, REQ_SAMPLE, 32'd20001, '0, '0, 32'd0, '0);
        add_row(0, REQ_SAMPLE, 32'd20001, '0, '0, 32'd0, '0);
        add_row(0, REQ_SAMPLE, 32'd26001, '0, '0, 32'd0, '0);
        // deadline wraps past zero and expires on the next sample
        add_row(1, REQ_START, 32'hFFFF_F000, '0, PMAX, 32'd0,
                make_burst(STEPS_NONE, PERIOD_NONE, 1'b0, PH_APPROACH, 1'b0));
        add_row(1, REQ_SAMPLE, 32'hFFFF_F100, PMAX, '0, 32'd0,
                make_burst(STEPS_NONE, PERIOD_NONE, 1'b0, PH_FINE, 1'b0));

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        while (plan_q.size() != 0)
        begin
            row = plan_q.pop_front();
            send_req(row.req, row.typed, row.result);
        end

        clock_ms = 32'hFFFF_F100;
        drive_runs(250);
        drain_bursts();

        load_settings('{32'd40, 32'd60, 16'd10, 20'd30, 20'd400, 20'd120, 20'd8, 20'd15});
        tick_span = 20;
        drive_runs(300);
        drain_bursts();

        load_settings('0);
        tick_span = 4;
        drive_runs(200);
        drain_bursts();

        load_settings('{'1, '1, '1, '1, '1, '1, '1, '1});
        tick_span = 30000;
        drive_runs(200);
        drain_bursts();

        // back-to-back requests while the output is held off
        load_settings(random_settings());
        tick_span = cfg.approach_ms / 2 + 1;
        no_gaps = 1'b1;
        choke_pending = 1'b1;
        drive_runs(300);
        drain_bursts();
        no_gaps = 1'b0;

        load_settings(random_settings());
        tick_span = cfg.approach_ms / 2 + 1;
        drive_runs(400);
        drain_bursts();

        if (n_errors == 0 && burst_q.size() == 0)
        begin
            $display("tb_pressure_stepper_sequencer: clean");
        end
        else
        begin
            $display("tb_pressure_stepper_sequencer: errors");
        end
        $finish;
    end

endmodule
